// File: rtl/sxd_pkg.sv
package sxd_pkg;

	localparam int STORE_SIZE  = 112;
	localparam int CHAN_W      = 7;
	localparam int BYTE_W      = 8;
	localparam int FRAME_IDX_W = 3;
	localparam int FRAME_POS_W = 4;
	localparam int ZERO_RUN_W  = 3;

	localparam logic [ZERO_RUN_W-1:0] ZERO_RUN_MAX  = 3'd4;
	localparam logic [ZERO_RUN_W-1:0] ZERO_RUN_SYNC = 3'd3;
	localparam logic [1:0]            NO_TRACK      = 2'd2;

	// Config register indexes
	localparam logic CFG_SCOPE_ENABLE    = 1'b0;
	localparam logic CFG_TRIGGER_CHANNEL = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLOCK = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_TRACK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_SYNC = 2'd0,
		PH_ADDR = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef struct packed {
		logic              we;
		logic [CHAN_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic              drive_enable;
		logic              drive_level;
		logic              scope_level;
		logic              request_refused;
		logic              track_power;
		logic              write_pending;
		logic              store_valid;
		logic [CHAN_W-1:0] stored_channel;
		logic [BYTE_W-1:0] stored_value;
	} result_t;

endpackage

// File: rtl/sxd_in_if.sv
interface sxd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       bus_bit;
	logic [6:0] chan;
	logic [7:0] value;

	modport source(output valid, cmd, bus_bit, chan, value, input ready);
	modport sink(input valid, cmd, bus_bit, chan, value, output ready);
endinterface

// File: rtl/sxd_out_if.sv
interface sxd_out_if;
	logic       valid;
	logic       ready;
	logic       drive_enable;
	logic       drive_level;
	logic       scope_level;
	logic [7:0] read_value;
	logic       request_refused;
	logic       track_power;
	logic       write_pending;
	logic       store_valid;
	logic [6:0] stored_channel;
	logic [7:0] stored_value;

	modport source(output valid, drive_enable, drive_level, scope_level, read_value,
		request_refused, track_power, write_pending, store_valid, stored_channel,
		stored_value, input ready);
	modport sink(input valid, drive_enable, drive_level, scope_level, read_value,
		request_refused, track_power, write_pending, store_valid, stored_channel,
		stored_value, output ready);
endinterface

// File: rtl/sxd_store.sv
module sxd_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sxd_pkg::store_wr_t          wr,
	input  logic                        rd_en,
	input  logic [sxd_pkg::CHAN_W-1:0]  rd_addr,
	output logic [sxd_pkg::BYTE_W-1:0]  rd_data
);

	logic [sxd_pkg::BYTE_W-1:0] mem [sxd_pkg::STORE_SIZE];
	logic [sxd_pkg::STORE_SIZE-1:0] valid_q;
	logic [sxd_pkg::BYTE_W-1:0] rdata_q;
	logic rhit_q;
	logic rd_in_range;

	assign rd_in_range = rd_addr < sxd_pkg::CHAN_W'(sxd_pkg::STORE_SIZE);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Entry not yet written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rhit_q  <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rhit_q <= rd_in_range && valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rhit_q ? rdata_q : '0;

endmodule

// File: rtl/sxd_ctrl.sv
module sxd_ctrl #(
	parameter int DATA_FRAMES = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [sxd_pkg::CHAN_W-1:0]  cfg_data,
	input  logic                        fire,
	input  sxd_pkg::cmd_t               cmd,
	input  logic                        bus_bit,
	input  logic [sxd_pkg::CHAN_W-1:0]  chan,
	input  logic [sxd_pkg::BYTE_W-1:0]  value,
	output sxd_pkg::store_wr_t          wr,
	output sxd_pkg::result_t            res
);

	localparam logic [sxd_pkg::FRAME_IDX_W-1:0] LAST_FRAME =
		sxd_pkg::FRAME_IDX_W'(DATA_FRAMES - 1);
	localparam logic [sxd_pkg::FRAME_IDX_W:0] NUM_FRAMES =
		(sxd_pkg::FRAME_IDX_W + 1)'(DATA_FRAMES);

	logic scope_en_q;
	logic [sxd_pkg::CHAN_W-1:0] trig_chan_q;

	sxd_pkg::phase_t phase_q, phase_d;
	logic [sxd_pkg::ZERO_RUN_W-1:0]  zero_run_q, zero_run_d;
	logic [2:0]                      abit_q, abit_d;
	logic [3:0]                      base_q, base_d;
	logic [sxd_pkg::FRAME_IDX_W-1:0] fidx_q, fidx_d;
	logic [sxd_pkg::FRAME_POS_W-1:0] fpos_q, fpos_d;
	logic [sxd_pkg::BYTE_W-1:0]      shift_q, shift_d;
	logic                            track_seen_q, track_seen_d;
	logic [1:0]                      track_req_q, track_req_d;
	logic                            pend_q, pend_d;
	logic                            inj_q, inj_d;
	logic [sxd_pkg::CHAN_W-1:0]      pend_ch_q, pend_ch_d;
	logic [sxd_pkg::BYTE_W-1:0]      pend_byte_q, pend_byte_d;
	logic                            oe_q, oe_d;
	logic                            ol_q, ol_d;
	logic                            scope_q, scope_d;

	logic [sxd_pkg::CHAN_W-1:0]      frame_ch;
	logic [sxd_pkg::FRAME_IDX_W:0]   fidx_inc;
	logic                            is_sep;
	logic                            is_dbit;
	logic [2:0]                      dbit_idx;
	logic                            refused;

	assign frame_ch = {LAST_FRAME - fidx_q, ~base_q};
	assign fidx_inc = {1'b0, fidx_q} + 1'b1;

	// Frame bit layout: data bit 0 at 0, separators at 2/5/8, end at 11
	always_comb begin
		is_sep   = 1'b0;
		is_dbit  = 1'b0;
		dbit_idx = 3'd0;
		unique case (fpos_q)
			4'd2, 4'd5, 4'd8: is_sep = 1'b1;
			4'd1:  begin is_dbit = 1'b1; dbit_idx = 3'd1; end
			4'd3:  begin is_dbit = 1'b1; dbit_idx = 3'd2; end
			4'd4:  begin is_dbit = 1'b1; dbit_idx = 3'd3; end
			4'd6:  begin is_dbit = 1'b1; dbit_idx = 3'd4; end
			4'd7:  begin is_dbit = 1'b1; dbit_idx = 3'd5; end
			4'd9:  begin is_dbit = 1'b1; dbit_idx = 3'd6; end
			4'd10: begin is_dbit = 1'b1; dbit_idx = 3'd7; end
			default: ;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		zero_run_d   = zero_run_q;
		abit_d       = abit_q;
		base_d       = base_q;
		fidx_d       = fidx_q;
		fpos_d       = fpos_q;
		shift_d      = shift_q;
		track_seen_d = track_seen_q;
		track_req_d  = track_req_q;
		pend_d       = pend_q;
		inj_d        = inj_q;
		pend_ch_d    = pend_ch_q;
		pend_byte_d  = pend_byte_q;
		oe_d         = oe_q;
		ol_d         = ol_q;
		scope_d      = scope_q;
		refused      = 1'b0;
		wr           = '0;

		unique case (cmd)
			sxd_pkg::CMD_CLOCK: begin
				unique case (phase_q)
					sxd_pkg::PH_ADDR: begin
						unique case (abit_q)
							3'd0: begin
								track_seen_d = bus_bit;
								if (track_req_q != sxd_pkg::NO_TRACK) begin
									oe_d = 1'b1;
									ol_d = track_req_q[0];
								end
							end
							3'd1: begin
								if (track_req_q != sxd_pkg::NO_TRACK) begin
									track_req_d = sxd_pkg::NO_TRACK;
									oe_d        = 1'b0;
								end
							end
							3'd2: base_d[3] = bus_bit;
							3'd3: base_d[2] = bus_bit;
							3'd5: base_d[1] = bus_bit;
							3'd6: base_d[0] = bus_bit;
							3'd7: begin
								phase_d = sxd_pkg::PH_DATA;
								fidx_d  = '0;
								fpos_d  = '0;
								shift_d = '0;
							end
							default: ;
						endcase
						abit_d = abit_q + 3'd1;
					end
					sxd_pkg::PH_DATA: begin
						if (is_sep) begin
							if (inj_q) begin
								ol_d = 1'b1;
							end
							fpos_d = fpos_q + 1'b1;
						end else if (fpos_q == '0) begin
							if (pend_q && frame_ch == pend_ch_q) begin
								oe_d  = 1'b1;
								ol_d  = pend_byte_q[0];
								inj_d = 1'b1;
							end else begin
								oe_d  = 1'b0;
								inj_d = 1'b0;
							end
							shift_d = {{(sxd_pkg::BYTE_W-1){1'b0}}, bus_bit};
							fpos_d  = fpos_q + 1'b1;
							if (scope_en_q) begin
								scope_d = frame_ch == trig_chan_q;
							end
						end else if (is_dbit) begin
							if (inj_q) begin
								ol_d = pend_byte_q[dbit_idx];
							end
							shift_d[dbit_idx] = bus_bit;
							fpos_d = fpos_q + 1'b1;
						end else begin
							// end of frame
							if (inj_q) begin
								ol_d   = 1'b1;
								oe_d   = 1'b0;
								inj_d  = 1'b0;
								pend_d = 1'b0;
							end
							if (frame_ch < sxd_pkg::CHAN_W'(sxd_pkg::STORE_SIZE)) begin
								wr.we   = 1'b1;
								wr.addr = frame_ch;
								wr.data = shift_q;
							end
							fpos_d = '0;
							if (fidx_inc >= NUM_FRAMES) begin
								fidx_d     = '0;
								phase_d    = sxd_pkg::PH_SYNC;
								zero_run_d = '0;
							end else begin
								fidx_d  = fidx_inc[sxd_pkg::FRAME_IDX_W-1:0];
								shift_d = '0;
							end
						end
					end
					default: begin
						if (!bus_bit) begin
							if (zero_run_q < sxd_pkg::ZERO_RUN_MAX) begin
								zero_run_d = zero_run_q + 1'b1;
							end
						end else if (zero_run_q == sxd_pkg::ZERO_RUN_SYNC) begin
							phase_d = sxd_pkg::PH_ADDR;
							base_d  = '0;
							abit_d  = '0;
						end else begin
							zero_run_d = '0;
						end
					end
				endcase
			end
			sxd_pkg::CMD_WRITE: begin
				if (pend_q) begin
					refused = 1'b1;
				end else begin
					pend_ch_d   = chan;
					pend_byte_d = value;
					pend_d      = 1'b1;
				end
			end
			sxd_pkg::CMD_READ: ;
			sxd_pkg::CMD_TRACK: begin
				if (value <= sxd_pkg::BYTE_W'(1)) begin
					track_req_d = value[1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.drive_enable    = oe_d;
		res.drive_level     = oe_d & ol_d;
		res.scope_level     = scope_d;
		res.request_refused = refused;
		res.track_power     = track_seen_d;
		res.write_pending   = pend_d;
		res.store_valid     = wr.we;
		res.stored_channel  = wr.addr;
		res.stored_value    = wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scope_en_q  <= 1'b0;
			trig_chan_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sxd_pkg::CFG_SCOPE_ENABLE:    scope_en_q  <= cfg_data[0];
				sxd_pkg::CFG_TRIGGER_CHANNEL: trig_chan_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sxd_pkg::PH_SYNC;
			zero_run_q   <= '0;
			abit_q       <= '0;
			base_q       <= '0;
			fidx_q       <= '0;
			fpos_q       <= '0;
			shift_q      <= '0;
			track_seen_q <= 1'b0;
			track_req_q  <= sxd_pkg::NO_TRACK;
			pend_q       <= 1'b0;
			inj_q        <= 1'b0;
			pend_ch_q    <= '0;
			pend_byte_q  <= '0;
			oe_q         <= 1'b0;
			ol_q         <= 1'b0;
			scope_q      <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			zero_run_q   <= zero_run_d;
			abit_q       <= abit_d;
			base_q       <= base_d;
			fidx_q       <= fidx_d;
			fpos_q       <= fpos_d;
			shift_q      <= shift_d;
			track_seen_q <= track_seen_d;
			track_req_q  <= track_req_d;
			pend_q       <= pend_d;
			inj_q        <= inj_d;
			pend_ch_q    <= pend_ch_d;
			pend_byte_q  <= pend_byte_d;
			oe_q         <= oe_d;
			ol_q         <= ol_d;
			scope_q      <= scope_d;
		end
	end

endmodule

// File: rtl/selectrix_bus_frame_decoder.sv
// A result is registered and valid in the cycle after its transaction is accepted.
// Throughput: 1 transaction per cycle unless the output stalls; decoder state
// updates in the accept cycle, as does the channel store read or write.
// Reset (arst_n low) returns the decoder to sync search and marks all 112
// store entries unwritten at once, so they read as zero; no clearing pass.
module selectrix_bus_frame_decoder #(
	parameter int DATA_FRAMES = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [6:0]         cfg_data,
	sxd_in_if.sink             in_ch,
	sxd_out_if.source          out_ch
);

	logic fire;
	logic rd_en;
	sxd_pkg::cmd_t      cmd;
	sxd_pkg::store_wr_t wr;
	sxd_pkg::result_t   res;
	sxd_pkg::result_t   res_s1;
	logic               valid_s1;
	logic               rd_s1;
	logic [sxd_pkg::BYTE_W-1:0] rd_data;

	assign cmd         = sxd_pkg::cmd_t'(in_ch.cmd);
	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;
	assign rd_en       = fire && cmd == sxd_pkg::CMD_READ;

	sxd_ctrl #(
		.DATA_FRAMES(DATA_FRAMES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.fire    (fire),
		.cmd     (cmd),
		.bus_bit (in_ch.bus_bit),
		.chan    (in_ch.chan),
		.value   (in_ch.value),
		.wr      (wr),
		.res     (res)
	);

	sxd_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fire ? wr : '0),
		.rd_en  (rd_en),
		.rd_addr(in_ch.chan),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else if (fire) begin
			rd_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
	end

	assign out_ch.valid           = valid_s1;
	assign out_ch.drive_enable    = res_s1.drive_enable;
	assign out_ch.drive_level     = res_s1.drive_level;
	assign out_ch.scope_level     = res_s1.scope_level;
	assign out_ch.read_value      = rd_s1 ? rd_data : '0;
	assign out_ch.request_refused = res_s1.request_refused;
	assign out_ch.track_power     = res_s1.track_power;
	assign out_ch.write_pending   = res_s1.write_pending;
	assign out_ch.store_valid     = res_s1.store_valid;
	assign out_ch.stored_channel  = res_s1.stored_channel;
	assign out_ch.stored_value    = res_s1.stored_value;

endmodule

// File: rtl/sxd_checker.sv
module sxd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       drive_enable,
	input logic       drive_level,
	input logic       request_refused,
	input logic       write_pending,
	input logic       store_valid,
	input logic [6:0] stored_channel,
	input logic [7:0] stored_value
);

	a_level_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_level |-> drive_enable)
		else $error("drive_level high while bus released");

	a_store_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !store_valid |-> stored_channel == 7'd0 && stored_value == 8'd0)
		else $error("store fields nonzero without store");

	a_refused_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && request_refused |-> write_pending)
		else $error("request refused with no pending write");

	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stored_value))
		else $error("stalled result dropped or changed");

endmodule

bind selectrix_bus_frame_decoder sxd_checker u_sxd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.drive_enable   (out_ch.drive_enable),
	.drive_level    (out_ch.drive_level),
	.request_refused(out_ch.request_refused),
	.write_pending  (out_ch.write_pending),
	.store_valid    (out_ch.store_valid),
	.stored_channel (out_ch.stored_channel),
	.stored_value   (out_ch.stored_value)
);
